>>> design/ilid_pkg.sv
// shared widths, codes and types for the indexed list block
package ilid_pkg;

    localparam int CAPACITY_DEFAULT = 64;

    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    localparam int IN_W  = 48;
    localparam int OUT_W = 48;

    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    localparam logic [WORD_W-1:0] DATA_NONE = '1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   data;
        logic [LEN_W-1:0]    length;
    } ilid_result_t;

endpackage

>>> design/ilid_ram.sv
// generic single write, single read ram with registered read data
module ilid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/ilid_seq.sv
// sequencer that carries out each operation on the entry ram, walking it one entry a cycle for shifts and searches
module ilid_seq import ilid_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [OP_W-1:0]             op,
    input  logic [POS_W-1:0]            pos,
    input  logic [WORD_W-1:0]           val,
    output logic                        idle,
    input  logic                        res_ready,
    output logic                        res_valid,
    output ilid_result_t                res,
    output logic                        wr_en,
    output logic [$clog2(CAPACITY)-1:0] wr_addr,
    output logic [WORD_W-1:0]           wr_data,
    output logic [$clog2(CAPACITY)-1:0] rd_addr,
    input  logic [WORD_W-1:0]           rd_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INS_SHIFT = 3'd1;
    localparam logic [2:0] S_INS_PUT   = 3'd2;
    localparam logic [2:0] S_DEL_SHIFT = 3'd3;
    localparam logic [2:0] S_RD_WAIT   = 3'd4;
    localparam logic [2:0] S_SRCH      = 3'd5;
    localparam logic [2:0] S_RESP      = 3'd6;

    logic [2:0]          state_reg,  state_next;
    logic [CW-1:0]       count_reg,  count_next;
    logic [AW-1:0]       idx_reg,    idx_next;
    logic [AW-1:0]       pos_reg,    pos_next;
    logic [WORD_W-1:0]   val_reg,    val_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [WORD_W-1:0]   data_reg,   data_next;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] count_x;
    logic [CW-1:0] count_m1;
    logic [AW-1:0] last_idx;
    logic          full;

    assign pos_x    = XW'(pos);
    assign count_x  = XW'(count_reg);
    assign count_m1 = count_reg - CW'(1);
    assign last_idx = count_m1[AW-1:0];
    assign full     = (count_reg == CW'(CAPACITY));

    assign idle       = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_RESP) && res_ready;
    assign res.status = status_reg;
    assign res.data   = data_reg;
    assign res.length = count_x[LEN_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        status_next = status_reg;
        data_next   = data_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = val;
        rd_addr     = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next  = S_RESP;
                    status_next = ST_OK;
                    data_next   = '0;
                    pos_next    = pos_x[AW-1:0];
                    val_next    = val;
                    case (op)
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[AW-1:0];
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            if (pos_x > count_x)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (pos_x == count_x)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = pos_x[AW-1:0];
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                // move entries up, starting from the top
                                rd_addr    = last_idx;
                                idx_next   = last_idx;
                                state_next = S_INS_SHIFT;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (pos_x >= count_x)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if ((pos_x + XW'(1)) == count_x)
                            begin
                                count_next = count_m1;
                            end
                            else
                            begin
                                rd_addr    = pos_x[AW-1:0] + AW'(1);
                                idx_next   = pos_x[AW-1:0] + AW'(1);
                                state_next = S_DEL_SHIFT;
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_x >= count_x)
                            begin
                                status_next = ST_RANGE;
                                data_next   = DATA_NONE;
                            end
                            else
                            begin
                                rd_addr    = pos_x[AW-1:0];
                                state_next = S_RD_WAIT;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOTFOUND;
                                data_next   = DATA_NONE;
                            end
                            else
                            begin
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = S_SRCH;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_INS_SHIFT:
            begin
                // data read last cycle lands one place higher
                wr_en   = 1'b1;
                wr_addr = idx_reg + AW'(1);
                wr_data = rd_data;
                if (idx_reg == pos_reg)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    rd_addr  = idx_reg - AW'(1);
                    idx_next = idx_reg - AW'(1);
                end
            end
            S_INS_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_RESP;
            end
            S_DEL_SHIFT:
            begin
                // data read last cycle lands one place lower
                wr_en   = 1'b1;
                wr_addr = idx_reg - AW'(1);
                wr_data = rd_data;
                if (idx_reg == last_idx)
                begin
                    count_next = count_m1;
                    state_next = S_RESP;
                end
                else
                begin
                    rd_addr  = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_RD_WAIT:
            begin
                data_next  = rd_data;
                state_next = S_RESP;
            end
            S_SRCH:
            begin
                if (rd_data == val_reg)
                begin
                    data_next  = WORD_W'(idx_reg);
                    state_next = S_RESP;
                end
                else if (idx_reg == last_idx)
                begin
                    status_next = ST_NOTFOUND;
                    data_next   = DATA_NONE;
                    state_next  = S_RESP;
                end
                else
                begin
                    rd_addr  = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        data_reg   <= data_next;
    end

endmodule

>>> design/indexed_list_insert_delete.sv
// top level of the indexed list with insert, delete, read and search
// an ordered list of signed 32-bit words held in a single ram of CAPACITY
// entries; every input item gives exactly one result item carrying a status,
// a data word (the word read, the position found, or -1 on a failed read or
// search) and the length after the operation. an item is taken only while the
// sequencer is idle, and its cost in cycles is set by the walk over the ram,
// which has one read and one write port and moves one entry a cycle:
// append, insert at the end, unused codes and failed checks go straight to
// the response; read waits on the ram; insert at p below count shifts the
// entries from the top down to p and writes the value; delete at p shifts
// the entries above p down (none for the last entry); search reads up from
// entry 0 to a match or the last entry. a result that finds the output slot
// still taken stalls the sequencer. the result waits in an output register,
// so the next item can be taken while the previous one is still unclaimed.
// a full list rejects append and insert; the position check comes first.
module indexed_list_insert_delete import ilid_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // operation [2:0], position [9:3], value [41:10], zero fill above
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // status [1:0], data [33:2], length [40:34], zero fill above
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int AW = $clog2(CAPACITY);

    logic              seq_idle;
    logic              start;
    logic              res_ready;
    logic              res_valid;
    ilid_result_t      res;

    // ram port wiring
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data;

    // output register
    logic              out_valid_reg, out_valid_next;
    ilid_result_t      out_res_reg,   out_res_next;

    assign s_axis_tready = seq_idle;
    assign start         = s_axis_tvalid && seq_idle;

    // the sequencer may hand over a result when the output slot is free
    // or being emptied this cycle
    assign res_ready = !out_valid_reg || m_axis_tready;

    ilid_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (s_axis_tdata[OP_W-1:0]),
        .pos       (s_axis_tdata[OP_W+POS_W-1:OP_W]),
        .val       (s_axis_tdata[OP_W+POS_W+WORD_W-1:OP_W+POS_W]),
        .idle      (seq_idle),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    ilid_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        {(OUT_W - LEN_W - WORD_W - STATUS_W){1'b0}},
        out_res_reg.length,
        out_res_reg.data,
        out_res_reg.status
    };

endmodule

>>> test/testbench.sv
// self-checking testbench for the indexed list block: directed and random items, scoreboard
module testbench;
    import ilid_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAP    = CAPACITY_DEFAULT;
    localparam int CYCLE_LIMIT = 1000000;
    // worst walk is a search or delete over a full list plus the result register
    localparam int SETTLE_CYCLES = LIST_CAP + 40;
    localparam int RANDOM_ITEMS  = 1600;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // operation [2:0], position [9:3], value [41:10], zero fill above
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // status [1:0], data [33:2], length [40:34], zero fill above
    logic [OUT_W-1:0] m_axis_tdata;

    // own copy of the list, updated as each item is accepted
    logic [WORD_W-1:0] list_words [LIST_CAP];
    int unsigned       list_len = 0;

    // results still owed by the block, oldest first
    ilid_result_t pending_results [$];
    ilid_result_t owed;

    int error_count = 0;
    int cycle_count = 0;

    // idle budgets per side, zero gives a stretch at full rate
    int tx_idle_max = 16;
    int rx_idle_max = 16;
    // long receiver hold-off, picked up by the receiver after its next item
    int rx_hold_request = 0;

    indexed_list_insert_delete #(
        .CAPACITY (LIST_CAP)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever
        begin
            #4ns clk = ~clk;
        end
    end

    // applies one operation to the list copy and gives the result it should yield
    function automatic ilid_result_t list_apply(input logic [OP_W-1:0] op,
                                                input logic [POS_W-1:0] pos,
                                                input logic [WORD_W-1:0] val);
        ilid_result_t r;
        int unsigned  p;
        int unsigned  i;
        bit           found;
        p = pos;
        r.status = ST_OK;
        r.data   = '0;
        found    = 1'b0;
        case (op)
            OP_APPEND:
            begin
                if (list_len >= LIST_CAP)
                    r.status = ST_FULL;
                else
                begin
                    list_words[list_len] = val;
                    list_len++;
                end
            end
            OP_INSERT:
            begin
                // range check takes priority over the full check
                if (p > list_len)
                    r.status = ST_RANGE;
                else if (list_len >= LIST_CAP)
                    r.status = ST_FULL;
                else
                begin
                    for (i = list_len; i > p; i--)
                        list_words[i] = list_words[i-1];
                    list_words[p] = val;
                    list_len++;
                end
            end
            OP_DELETE:
            begin
                if (p >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = p; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            OP_READ:
            begin
                if (p >= list_len)
                begin
                    r.status = ST_RANGE;
                    r.data   = DATA_NONE;
                end
                else
                    r.data = list_words[p];
            end
            OP_SEARCH:
            begin
                // first matching position wins
                for (i = 0; i < list_len; i++)
                begin
                    if (!found && list_words[i] == val)
                    begin
                        found  = 1'b1;
                        r.data = WORD_W'(i);
                    end
                end
                if (!found)
                begin
                    r.status = ST_NOTFOUND;
                    r.data   = DATA_NONE;
                end
            end
            default:
            begin
                // unused opcodes leave everything alone
            end
        endcase
        r.length = LEN_W'(list_len);
        return r;
    endfunction

    // scoreboard: predict on input acceptance first, then check any result
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            pending_results.push_back(list_apply(s_axis_tdata[2:0], s_axis_tdata[9:3],
                                                 s_axis_tdata[41:10]));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with no expectation waiting: tdata %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                owed = pending_results.pop_front();
                if (m_axis_tdata[1:0] !== owed.status)
                begin
                    $error("status mismatch: expected %0d, got %0d",
                           owed.status, m_axis_tdata[1:0]);
                    error_count++;
                end
                if (m_axis_tdata[33:2] !== owed.data)
                begin
                    $error("data mismatch: expected %0d, got %0d",
                           $signed(owed.data), $signed(m_axis_tdata[33:2]));
                    error_count++;
                end
                if (m_axis_tdata[40:34] !== owed.length)
                begin
                    $error("length mismatch: expected %0d, got %0d",
                           owed.length, m_axis_tdata[40:34]);
                    error_count++;
                end
            end
        end
    end

    // receiver: random stall before each result, or a long hold when asked
    initial
    begin
        int hold;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold_request > 0)
            begin
                hold = rx_hold_request;
                rx_hold_request = 0;
            end
            else
                hold = $urandom_range(0, rx_idle_max);
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL indexed_list_insert_delete");
        $finish;
    end

    // offers one item after a random gap and returns at the edge it is taken
    task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [WORD_W-1:0] val);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - 42){1'b0}}, val, pos, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // stops offering and waits until every owed result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // words drawn often from a small pool or the list itself so that searches hit and duplicates occur
    function automatic logic [WORD_W-1:0] pick_word();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return WORD_W'($signed($urandom_range(0, 15)) - 8);
        else if (sel < 65 && list_len > 0 && list_len <= LIST_CAP)
            return list_words[$urandom_range(0, list_len - 1)];
        else if (sel < 70)
            return 32'h7fff_ffff;
        else if (sel < 75)
            return 32'h8000_0000;
        else
            return $urandom();
    endfunction

    // failing cases on an empty list
    task automatic test_empty_list();
        send_item(OP_SEARCH, 7'd0, 32'd0);
        send_item(OP_READ, 7'd0, 32'd0);
        send_item(OP_DELETE, 7'd0, 32'd0);
        send_item(OP_INSERT, 7'd1, 32'd5);
        send_item(OP_READ, 7'd127, 32'hffff_ffff);
    endtask

    // edits at the front, middle and end, with extreme words
    task automatic test_basic_edits();
        send_item(OP_INSERT, 7'd0, 32'd11);          // insert at length acts as append
        send_item(OP_APPEND, 7'd0, 32'h7fff_ffff);
        send_item(OP_APPEND, 7'd127, 32'h8000_0000);
        send_item(OP_INSERT, 7'd3, 32'd0);           // at the end
        send_item(OP_INSERT, 7'd1, 32'd11);          // duplicate in the middle
        send_item(OP_INSERT, 7'd0, 32'hffff_ffff);   // at the front
        send_item(OP_READ, 7'd0, 32'd0);
        send_item(OP_READ, 7'd5, 32'd0);             // last entry
        send_item(OP_READ, 7'd6, 32'd0);             // one past the end
        send_item(OP_SEARCH, 7'd0, 32'd11);          // first of two matches
        send_item(OP_SEARCH, 7'd0, 32'h8000_0000);
        send_item(OP_SEARCH, 7'd0, 32'd12345);
        send_item(OP_INSERT, 7'd64, 32'd1);          // far out of range
        send_item(OP_DELETE, 7'd2, 32'd0);
        send_item(OP_DELETE, 7'd4, 32'd0);           // last entry
        send_item(OP_DELETE, 7'd4, 32'd0);           // now out of range
    endtask

    // unused opcodes must change nothing
    task automatic test_unused_opcodes();
        send_item(OP_W'(5), 7'd0, 32'd0);
        send_item(OP_W'(6), 7'd64, 32'hffff_ffff);
        send_item(OP_W'(7), 7'd127, 32'h5a5a_a5a5);
        send_item(OP_READ, 7'd0, 32'd0);
    endtask

    // fill to capacity, hit the full and range cases, then empty it again
    task automatic test_full_list();
        int n;
        int k;
        wait_drained();
        n = LIST_CAP - list_len;
        for (k = 0; k < n; k++)
            send_item(OP_APPEND, POS_W'($urandom_range(0, 127)), pick_word());
        send_item(OP_APPEND, 7'd0, 32'd1);
        send_item(OP_INSERT, POS_W'(LIST_CAP), 32'd2);      // position valid, list full
        send_item(OP_INSERT, POS_W'(LIST_CAP + 1), 32'd3);  // range wins over full
        send_item(OP_INSERT, 7'd0, 32'd4);
        send_item(OP_READ, POS_W'(LIST_CAP - 1), 32'd0);
        send_item(OP_READ, POS_W'(LIST_CAP), 32'd0);
        send_item(OP_DELETE, POS_W'(LIST_CAP), 32'd0);
        send_item(OP_SEARCH, 7'd0, 32'h1234_5678);          // walk over a full list
        send_item(OP_DELETE, 7'd0, 32'd0);                  // longest shift
        send_item(OP_INSERT, 7'd0, 32'h8000_0000);          // longest shift up
        wait_drained();
        for (k = LIST_CAP; k > 0; k--)
        begin
            send_item(OP_DELETE, POS_W'($urandom_range(0, k - 1)), 32'd0);
            if (k % 8 == 0)
                send_item(OP_SEARCH, 7'd0, pick_word());
        end
        send_item(OP_DELETE, 7'd0, 32'd0);
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_output_stall();
        int k;
        wait_drained();
        tx_idle_max = 0;
        rx_hold_request = 300;
        for (k = 0; k < 30; k++)
            send_item(OP_W'($urandom_range(0, 4)), POS_W'($urandom_range(0, 8)),
                      pick_word());
        tx_idle_max = 16;
        wait_drained();
    endtask

    // random mix that swings the list between nearly empty and full
    task automatic test_random_mix(input int items);
        int          k;
        int unsigned r;
        int unsigned len_now;
        bit          growing;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        growing = 1'b1;
        for (k = 0; k < items; k++)
        begin
            // change the idling pattern now and then, including full-rate stretches
            if (k % 150 == 0)
            begin
                tx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
                rx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
            end
            len_now = list_len;
            if (len_now >= LIST_CAP - 1)
                growing = 1'b0;
            else if (len_now <= 2)
                growing = 1'b1;
            r = $urandom_range(0, 99);
            if (growing)
                op = (r < 25) ? OP_APPEND : (r < 50) ? OP_INSERT : (r < 60) ? OP_DELETE :
                     (r < 75) ? OP_READ : (r < 97) ? OP_SEARCH : OP_W'($urandom_range(5, 7));
            else
                op = (r < 10) ? OP_APPEND : (r < 20) ? OP_INSERT : (r < 55) ? OP_DELETE :
                     (r < 75) ? OP_READ : (r < 97) ? OP_SEARCH : OP_W'($urandom_range(5, 7));
            // mostly valid positions, some at the length and some anywhere
            r = $urandom_range(0, 9);
            if (r == 0)
                pos = POS_W'($urandom_range(0, 127));
            else if (r == 1)
                pos = POS_W'(len_now);
            else if (op == OP_INSERT)
                pos = POS_W'($urandom_range(0, len_now));
            else
                pos = POS_W'($urandom_range(0, (len_now > 0) ? len_now - 1 : 0));
            send_item(op, pos, pick_word());
        end
        tx_idle_max = 16;
        rx_idle_max = 16;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_basic_edits();
        test_unused_opcodes();
        test_full_list();
        test_output_stall();
        test_random_mix(RANDOM_ITEMS);

        // all stimulus taken: wait for the last results and a quiet tail
        wait_drained();
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("PASS indexed_list_insert_delete");
        else
            $display("FAIL indexed_list_insert_delete");
        $finish;
    end

endmodule

>>> indexed_list_insert_delete.f
design/ilid_pkg.sv
design/ilid_ram.sv
design/ilid_seq.sv
design/indexed_list_insert_delete.sv
test/testbench.sv
